@@ src/dbjc_pkg.sv @@
// ----------------------------------------------------------------------------
// dbjc_pkg: shared types, constants and saturation helpers
// Widths, register indexes, step codes of the per-joint sequence and the
// saturating arithmetic used by the backstepping joint controller.
// ----------------------------------------------------------------------------
package dbjc_pkg;

    localparam int JOINTS    = 4;
    localparam int VALUE_W   = 32;
    localparam int GAIN_W    = 16;
    localparam int JOINT_W   = (JOINTS > 1) ? $clog2(JOINTS) : 1;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;
    localparam int FRAC_GAIN = 8;
    localparam int PROD_W    = VALUE_W + GAIN_W + 1;
    localparam int PHASE_W   = 3;

    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic        [GAIN_W-1:0]  t_gain;
    typedef logic        [JOINT_W-1:0] t_joint;
    typedef logic        [PHASE_W-1:0] t_phase;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OUTER_GAIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_REF0  = 3'd3;

    // Register reset values
    localparam t_gain OUTER_GAIN_RST  = 16'd8960;
    localparam t_gain INNER_GAIN_RST  = 16'd10240;
    localparam t_gain SAMPLE_RATE_RST = 16'd100;
    localparam t_value START_REF_RST [JOINTS] = '{
        32'sd44499, 32'sd46410, 32'sd44846, 32'sd41756
    };

    // Operation codes
    localparam logic OP_SET_REF = 1'b0;
    localparam logic OP_MEASURE = 1'b1;

    // Per-joint sequence steps
    localparam t_phase PH_REF_DIFF  = 3'd0;
    localparam t_phase PH_POS_ERR   = 3'd1;
    localparam t_phase PH_REF_TERM  = 3'd2;
    localparam t_phase PH_VIRTUAL   = 3'd3;
    localparam t_phase PH_VIRT_DIFF = 3'd4;
    localparam t_phase PH_VEL_ERR   = 3'd5;
    localparam t_phase PH_VIRT_TERM = 3'd6;
    localparam t_phase PH_DRIVE     = 3'd7;

    localparam t_value VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam t_value VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    typedef struct packed {
        logic   load_ref;
        logic   capture;
        logic   step;
        t_phase phase;
        t_joint joint;
        logic   out_load;
    } t_cmd;

    function automatic t_value sat_sum(input logic signed [VALUE_W:0] x);
        t_value r;
        if (x[VALUE_W] != x[VALUE_W-1]) begin
            r = x[VALUE_W] ? VALUE_MIN : VALUE_MAX;
        end else begin
            r = x[VALUE_W-1:0];
        end
        return r;
    endfunction

    function automatic t_value add_sat(input t_value a, input t_value b);
        logic signed [VALUE_W:0] s;
        s = $signed({a[VALUE_W-1], a}) + $signed({b[VALUE_W-1], b});
        return sat_sum(s);
    endfunction

    function automatic t_value sub_sat(input t_value a, input t_value b);
        logic signed [VALUE_W:0] s;
        s = $signed({a[VALUE_W-1], a}) - $signed({b[VALUE_W-1], b});
        return sat_sum(s);
    endfunction

    function automatic t_value sat_prod(input logic signed [PROD_W-1:0] x);
        logic [PROD_W-VALUE_W:0] top;
        t_value r;
        top = x[PROD_W-1:VALUE_W-1];
        if ((&top) || !(|top)) begin
            r = x[VALUE_W-1:0];
        end else begin
            r = x[PROD_W-1] ? VALUE_MIN : VALUE_MAX;
        end
        return r;
    endfunction

endpackage

@@ src/dbjc_ctrl.sv @@
// ----------------------------------------------------------------------------
// dbjc_ctrl: sequencer of the joint controller
// Accepts items, walks each joint of a measurement through the eight-step
// sequence and hands the finished drive set to the output register.
// ----------------------------------------------------------------------------
module dbjc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic           i_operation,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  logic           i_ref_seen,
    output dbjc_pkg::t_cmd o_cmd
);
    import dbjc_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] r_state, n_state;
    t_phase     r_phase, n_phase;
    t_joint     r_joint, n_joint;
    logic       r_out_valid, n_out_valid;
    logic       w_accept;
    logic       w_slot_free;

    // hold off input transfers while reset is asserted
    assign o_in_ready  = (r_state == ST_IDLE) && i_rst_n;
    assign o_out_valid = r_out_valid;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_joint     = r_joint;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_cmd.phase = r_phase;
        o_cmd.joint = r_joint;

        // drop the pending result once it transfers
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_operation == OP_SET_REF) begin
                        o_cmd.load_ref = 1'b1;
                    end else if (i_ref_seen) begin
                        o_cmd.capture = 1'b1;
                        n_state       = ST_CALC;
                        n_phase       = PH_REF_DIFF;
                        n_joint       = '0;
                    end
                end
            end
            ST_CALC: begin
                o_cmd.step = 1'b1;
                if (r_phase == PH_DRIVE) begin
                    n_phase = PH_REF_DIFF;
                    if (r_joint == JOINT_W'(JOINTS - 1)) begin
                        n_state = ST_DONE;
                    end else begin
                        n_joint = r_joint + 1'b1;
                    end
                end else begin
                    n_phase = r_phase + 1'b1;
                end
            end
            ST_DONE: begin
                if (w_slot_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_REF_DIFF;
            r_joint     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_joint     <= n_joint;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ src/dbjc_datapath.sv @@
// ----------------------------------------------------------------------------
// dbjc_datapath: storage and arithmetic of the joint controller
// Holds references, measurements, previous values and gains, and computes
// one joint at a time on a single registered multiplier.
// ----------------------------------------------------------------------------
module dbjc_datapath (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  dbjc_pkg::t_cmd                         i_cmd,
    input  dbjc_pkg::t_value                       i_value [dbjc_pkg::JOINTS],
    input  dbjc_pkg::t_value                       i_speed [dbjc_pkg::JOINTS],
    input  logic                                   i_cfg_we,
    input  logic [dbjc_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [dbjc_pkg::CFG_W-1:0]             i_cfg_data,
    output logic                                   o_ref_seen,
    output dbjc_pkg::t_value                       o_drive [dbjc_pkg::JOINTS]
);
    import dbjc_pkg::*;

    t_gain  r_outer_gain;
    t_gain  r_inner_gain;
    t_gain  r_sample_rate;
    logic   r_ref_seen;

    t_value r_cur_ref   [JOINTS];
    t_value r_prev_ref  [JOINTS];
    t_value r_prev_virt [JOINTS];
    t_value r_pos       [JOINTS];
    t_value r_vel       [JOINTS];
    t_value r_drive     [JOINTS];
    t_value r_out       [JOINTS];

    t_value                    r_opa;
    t_gain                     r_opb;
    logic signed [PROD_W-1:0]  r_prod;
    t_value                    r_acc;
    t_value                    r_virt;
    t_value                    r_e2;

    t_value w_ref, w_pos, w_vel, w_pref, w_pvirt;
    t_value w_rate_term, w_gain_term;
    logic signed [PROD_W-1:0]  w_prod_shift;
    logic                      w_cfg_start;
    logic [CFG_IDX_W-1:0]      w_cfg_start_idx;

    assign w_ref   = r_cur_ref[i_cmd.joint];
    assign w_pos   = r_pos[i_cmd.joint];
    assign w_vel   = r_vel[i_cmd.joint];
    assign w_pref  = r_prev_ref[i_cmd.joint];
    assign w_pvirt = r_prev_virt[i_cmd.joint];

    // floor shift of a Q8.8 gain product back to Q16.16
    assign w_prod_shift = r_prod >>> FRAC_GAIN;
    assign w_rate_term  = sat_prod(r_prod);
    assign w_gain_term  = sat_prod(w_prod_shift);

    assign w_cfg_start_idx = i_cfg_index - REG_START_REF0;
    assign w_cfg_start = i_cfg_we && (i_cfg_index >= REG_START_REF0) &&
                         (w_cfg_start_idx < CFG_IDX_W'(JOINTS));

    assign o_ref_seen = r_ref_seen;
    assign o_drive    = r_out;

    // configuration and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outer_gain  <= OUTER_GAIN_RST;
            r_inner_gain  <= INNER_GAIN_RST;
            r_sample_rate <= SAMPLE_RATE_RST;
            r_ref_seen    <= 1'b0;
            for (int j = 0; j < JOINTS; j++) begin
                r_prev_ref[j]  <= START_REF_RST[j];
                r_prev_virt[j] <= '0;
            end
        end else begin
            if (i_cfg_we && i_cfg_index == REG_OUTER_GAIN) begin
                r_outer_gain <= i_cfg_data[GAIN_W-1:0];
            end
            if (i_cfg_we && i_cfg_index == REG_INNER_GAIN) begin
                r_inner_gain <= i_cfg_data[GAIN_W-1:0];
            end
            if (i_cfg_we && i_cfg_index == REG_SAMPLE_RATE) begin
                r_sample_rate <= i_cfg_data[GAIN_W-1:0];
            end
            if (w_cfg_start) begin
                r_prev_ref[w_cfg_start_idx[JOINT_W-1:0]] <= i_cfg_data[VALUE_W-1:0];
            end
            if (i_cmd.load_ref) begin
                r_ref_seen <= 1'b1;
            end
            if (i_cmd.step && i_cmd.phase == PH_DRIVE) begin
                r_prev_ref[i_cmd.joint]  <= w_ref;
                r_prev_virt[i_cmd.joint] <= r_virt;
            end
        end
    end

    // payload and arithmetic
    always_ff @(posedge i_clk) begin
        r_prod <= r_opa * $signed({1'b0, r_opb});

        if (i_cmd.load_ref) begin
            for (int j = 0; j < JOINTS; j++) begin
                r_cur_ref[j] <= i_value[j];
            end
        end
        if (i_cmd.capture) begin
            for (int j = 0; j < JOINTS; j++) begin
                r_pos[j] <= i_value[j];
                r_vel[j] <= i_speed[j];
            end
        end
        if (i_cmd.out_load) begin
            r_out <= r_drive;
        end

        if (i_cmd.step) begin
            unique case (i_cmd.phase)
                PH_REF_DIFF: begin
                    r_opa <= sub_sat(w_ref, w_pref);
                    r_opb <= r_sample_rate;
                end
                PH_POS_ERR: begin
                    r_opa <= sub_sat(w_ref, w_pos);
                    r_opb <= r_outer_gain;
                end
                PH_REF_TERM: begin
                    r_acc <= w_rate_term;
                end
                PH_VIRTUAL: begin
                    r_virt <= add_sat(r_acc, w_gain_term);
                end
                PH_VIRT_DIFF: begin
                    r_opa <= sub_sat(r_virt, w_pvirt);
                    r_opb <= r_sample_rate;
                    r_e2  <= sub_sat(r_virt, w_vel);
                end
                PH_VEL_ERR: begin
                    r_opa <= r_e2;
                    r_opb <= r_inner_gain;
                end
                PH_VIRT_TERM: begin
                    r_acc <= w_rate_term;
                end
                PH_DRIVE: begin
                    r_drive[i_cmd.joint] <= add_sat(r_acc, w_gain_term);
                end
            endcase
        end
    end

endmodule

@@ src/discrete_backstepping_joint_control.sv @@
// ----------------------------------------------------------------------------
// discrete_backstepping_joint_control: four-joint backstepping controller
// Set-reference items store the joint references; measurement items give one
// set of saturated Q16.16 drives once a reference is present.
//
//  channel  | handshake                     | payload
//  ---------+-------------------------------+-----------------------------------
//  input    | i_in_valid / o_in_ready       | i_operation, i_value_*, i_speed_*
//  output   | o_out_valid / i_out_ready     | o_drive_*
//  config   | i_cfg_we (no wait)            | i_cfg_index, i_cfg_data
//
// A set-reference item, or a measurement before any reference, leaves the block
// idle. A measurement is captured, then each joint runs eight steps through
// the one shared 32 x 17 multiplier; no new item is taken until it is done.
// The result waits in an output register; a stalled output holds the block
// in its done state until that register frees. Reset is synchronous, low.
// ----------------------------------------------------------------------------
module discrete_backstepping_joint_control (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_operation,
    input  dbjc_pkg::t_value                    i_value_0,
    input  dbjc_pkg::t_value                    i_value_1,
    input  dbjc_pkg::t_value                    i_value_2,
    input  dbjc_pkg::t_value                    i_value_3,
    input  dbjc_pkg::t_value                    i_speed_0,
    input  dbjc_pkg::t_value                    i_speed_1,
    input  dbjc_pkg::t_value                    i_speed_2,
    input  dbjc_pkg::t_value                    i_speed_3,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output dbjc_pkg::t_value                    o_drive_0,
    output dbjc_pkg::t_value                    o_drive_1,
    output dbjc_pkg::t_value                    o_drive_2,
    output dbjc_pkg::t_value                    o_drive_3,
    input  logic                                i_cfg_we,
    input  logic [dbjc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [dbjc_pkg::CFG_W-1:0]          i_cfg_data
);
    import dbjc_pkg::*;

    t_cmd   w_cmd;
    logic   w_ref_seen;
    t_value w_value [JOINTS];
    t_value w_speed [JOINTS];
    t_value w_drive [JOINTS];

    assign w_value[0] = i_value_0;
    assign w_value[1] = i_value_1;
    assign w_value[2] = i_value_2;
    assign w_value[3] = i_value_3;
    assign w_speed[0] = i_speed_0;
    assign w_speed[1] = i_speed_1;
    assign w_speed[2] = i_speed_2;
    assign w_speed[3] = i_speed_3;

    assign o_drive_0 = w_drive[0];
    assign o_drive_1 = w_drive[1];
    assign o_drive_2 = w_drive[2];
    assign o_drive_3 = w_drive[3];

    dbjc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_operation),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_ref_seen  (w_ref_seen),
        .o_cmd       (w_cmd)
    );

    dbjc_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_value     (w_value),
        .i_speed     (w_speed),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_ref_seen  (w_ref_seen),
        .o_drive     (w_drive)
    );

endmodule

@@ tb/discrete_backstepping_joint_control_tb.sv @@
// ----------------------------------------------------------------------------
// discrete_backstepping_joint_control_tb: self-checking bench for the joint
// controller
// Drives set-reference and measurement transfers through the valid/ready
// input, predicts the four saturated Q16.16 drives of each measurement after a reference, and
// compares each output transfer against the oldest pending prediction.
// Directed cases cover field extremes, every register and the corner cases;
// random traffic follows with changing register settings and idle patterns.
// ----------------------------------------------------------------------------
module discrete_backstepping_joint_control_tb;
    import dbjc_pkg::*;

    typedef logic [JOINTS-1:0][VALUE_W-1:0] t_joint_vec;

    localparam int     SETTLE_CYCLES = 40;
    localparam int     LIMIT_TIME    = 4_000_000;
    localparam longint SAT_HI        = longint'(VALUE_MAX);
    localparam longint SAT_LO        = longint'(VALUE_MIN);
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = CFG_IDX_W'(REG_START_REF0 + JOINTS);

    logic   i_clk       = 1'b0;
    logic   i_rst_n     = 1'b0;
    logic   i_in_valid  = 1'b0;
    logic   o_in_ready;
    logic   i_operation = OP_SET_REF;
    t_value i_value_0   = '0;
    t_value i_value_1   = '0;
    t_value i_value_2   = '0;
    t_value i_value_3   = '0;
    t_value i_speed_0   = '0;
    t_value i_speed_1   = '0;
    t_value i_speed_2   = '0;
    t_value i_speed_3   = '0;
    logic   o_out_valid;
    logic   i_out_ready = 1'b0;
    t_value o_drive_0;
    t_value o_drive_1;
    t_value o_drive_2;
    t_value o_drive_3;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data  = '0;

    t_joint_vec drives_seen;
    assign drives_seen = {o_drive_3, o_drive_2, o_drive_1, o_drive_0};

    // Controller state as seen from outside
    longint k_pos = longint'(OUTER_GAIN_RST);
    longint k_vel = longint'(INNER_GAIN_RST);
    longint rate_hz = longint'(SAMPLE_RATE_RST);
    longint ref_now [JOINTS];
    longint ref_last [JOINTS];
    longint virt_last [JOINTS];
    logic   ref_loaded = 1'b0;

    t_joint_vec pending_drives [$];
    int fail_count  = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    discrete_backstepping_joint_control u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_operation),
        .i_value_0   (i_value_0),
        .i_value_1   (i_value_1),
        .i_value_2   (i_value_2),
        .i_value_3   (i_value_3),
        .i_speed_0   (i_speed_0),
        .i_speed_1   (i_speed_1),
        .i_speed_2   (i_speed_2),
        .i_speed_3   (i_speed_3),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_drive_0   (o_drive_0),
        .o_drive_1   (o_drive_1),
        .o_drive_2   (o_drive_2),
        .o_drive_3   (o_drive_3),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        for (int j = 0; j < JOINTS; j++) begin
            ref_now[j]   = 0;
            ref_last[j]  = longint'(START_REF_RST[j]);
            virt_last[j] = 0;
        end
    end

    // ------------------------------------------------------------------
    // Drive prediction
    // ------------------------------------------------------------------
    function automatic longint clamp32(input longint x);
        if (x > SAT_HI) return SAT_HI;
        if (x < SAT_LO) return SAT_LO;
        return x;
    endfunction

    // Q8.8 gain: exact product, floor shift back to Q16.16
    function automatic longint scale_gain(input longint a, input longint g);
        longint prod;
        prod = a * g;
        return clamp32(prod >>> FRAC_GAIN);
    endfunction

    function automatic longint scale_rate(input longint a);
        return clamp32(a * rate_hz);
    endfunction

    task automatic compute_drives(input logic op, input t_joint_vec vals,
                                  input t_joint_vec spds);
        t_joint_vec drv_set;
        longint r, p, v, e1, dref, virt, e2, dvirt, drv;
        if (op == OP_SET_REF) begin
            for (int j = 0; j < JOINTS; j++) ref_now[j] = longint'($signed(vals[j]));
            ref_loaded = 1'b1;
        end else if (ref_loaded) begin
            for (int j = 0; j < JOINTS; j++) begin
                r     = ref_now[j];
                p     = longint'($signed(vals[j]));
                v     = longint'($signed(spds[j]));
                e1    = clamp32(r - p);
                dref  = scale_rate(clamp32(r - ref_last[j]));
                virt  = clamp32(dref + scale_gain(e1, k_pos));
                e2    = clamp32(virt - v);
                dvirt = scale_rate(clamp32(virt - virt_last[j]));
                drv   = clamp32(dvirt + scale_gain(e2, k_vel));
                ref_last[j]  = r;
                virt_last[j] = virt;
                drv_set[j]   = drv[VALUE_W-1:0];
            end
            pending_drives.push_back(drv_set);
        end
    endtask

    // ------------------------------------------------------------------
    // Output side: random stalls and checking
    // ------------------------------------------------------------------
    task automatic note_fail(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("%s", msg);
    endtask

    always @(posedge i_clk) begin : drive_check
        t_joint_vec want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
            if (o_out_valid && i_out_ready) begin
                if (pending_drives.size() == 0) begin
                    note_fail($sformatf("t=%0t drive transfer with nothing pending: %h",
                                        $time, drives_seen));
                end else begin
                    want = pending_drives.pop_front();
                    for (int j = 0; j < JOINTS; j++) begin
                        if (drives_seen[j] !== want[j]) begin
                            note_fail($sformatf("t=%0t drive_%0d expected %h got %h",
                                                $time, j, want[j], drives_seen[j]));
                        end
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    task automatic send_item(input logic op, input t_joint_vec vals, input t_joint_vec spds);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_value_0   <= vals[0];
        i_value_1   <= vals[1];
        i_value_2   <= vals[2];
        i_value_3   <= vals[3];
        i_speed_0   <= spds[0];
        i_speed_1   <= spds[1];
        i_speed_2   <= spds[2];
        i_speed_3   <= spds[3];
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        compute_drives(op, vals, spds);
    endtask

    // Drop valid, wait for every pending drive, then let the block go idle
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_drives.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_OUTER_GAIN:  k_pos   = longint'(data[GAIN_W-1:0]);
            REG_INNER_GAIN:  k_vel   = longint'(data[GAIN_W-1:0]);
            REG_SAMPLE_RATE: rate_hz = longint'(data[GAIN_W-1:0]);
            default: begin
                if (idx >= REG_START_REF0 && int'(idx) < int'(REG_START_REF0) + JOINTS)
                    ref_last[JOINT_W'(idx - REG_START_REF0)] =
                        longint'($signed(data[VALUE_W-1:0]));
            end
        endcase
        @(posedge i_clk);
    endtask

    function automatic t_joint_vec fill(input t_value x);
        t_joint_vec v;
        for (int j = 0; j < JOINTS; j++) v[j] = x;
        return v;
    endfunction

    function automatic t_value rand_value();
        case ($urandom_range(7))
            0: begin
                case ($urandom_range(3))
                    0: return VALUE_MAX;
                    1: return VALUE_MIN;
                    2: return '0;
                    default: return '1;
                endcase
            end
            1, 2: return $urandom();
            default: return int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
        endcase
    endfunction

    function automatic t_value near(input t_value base);
        int d;
        d = int'($urandom_range(0, 8191)) - 4096;
        return base + d;
    endfunction

    function automatic t_value rand_speed();
        if ($urandom_range(9) == 0) return rand_value();
        return int'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
    endfunction

    function automatic t_gain rand_gain();
        case ($urandom_range(5))
            0: return GAIN_W'($urandom_range(0, 65535));
            1: return GAIN_W'($urandom_range(0, 255));
            default: return GAIN_W'($urandom_range(256, 16384));
        endcase
    endfunction

    function automatic t_gain rand_rate();
        case ($urandom_range(5))
            0: return 16'd1;
            1: return 16'hFFFF;
            default: return GAIN_W'($urandom_range(1, 2000));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_measure_before_reference();
        send_item(OP_MEASURE, fill(VALUE_MAX), fill(VALUE_MIN));
        send_item(OP_MEASURE, fill(VALUE_MIN), fill(VALUE_MAX));
        settle();
    endtask

    task automatic test_reset_registers();
        send_item(OP_SET_REF, fill(32'sh0001_0000), fill('0));
        send_item(OP_MEASURE, fill('0), fill('0));
        send_item(OP_MEASURE, fill(32'sh0000_F000), fill(32'sh0000_0800));
    endtask

    task automatic test_field_extremes();
        // speeds on a set-reference transfer carry no meaning
        send_item(OP_SET_REF, fill(VALUE_MAX), fill(VALUE_MIN));
        send_item(OP_MEASURE, fill(VALUE_MIN), fill(VALUE_MAX));
        send_item(OP_SET_REF, fill(VALUE_MIN), fill(VALUE_MAX));
        send_item(OP_MEASURE, fill(VALUE_MAX), fill(VALUE_MIN));
        send_item(OP_SET_REF, fill('0), fill('1));
        send_item(OP_MEASURE, fill('0), fill('0));
        send_item(OP_MEASURE, {32'hFFFF_FFFF, VALUE_MIN, 32'h0, VALUE_MAX},
                  {VALUE_MAX, 32'h1, VALUE_MIN, 32'hFFFF_FFFF});
    endtask

    task automatic test_register_writes();
        t_joint_vec rnd;
        settle();
        write_reg(REG_OUTER_GAIN, 32'hA5A5_FFFF);
        write_reg(REG_INNER_GAIN, 32'h5A5A_FFFF);
        write_reg(REG_SAMPLE_RATE, 32'hC3C3_FFFF);
        write_reg(REG_START_REF0, VALUE_MIN);
        write_reg(CFG_IDX_W'(REG_START_REF0 + 1), VALUE_MAX);
        write_reg(CFG_IDX_W'(REG_START_REF0 + 2), 32'h0);
        write_reg(CFG_IDX_W'(REG_START_REF0 + 3), 32'hFFFF_FFFF);
        write_reg(REG_UNMAPPED, $urandom());
        send_item(OP_SET_REF, {32'sh0000_1000, 32'sh0001_0000, 32'shFFFF_0000, 32'sh0000_0001},
                  fill('0));
        send_item(OP_MEASURE, fill('0), fill(32'sh0000_0100));
        // zero rate kills both derivative terms, zero gains kill the rest
        settle();
        write_reg(REG_OUTER_GAIN, 32'h0);
        write_reg(REG_INNER_GAIN, 32'h0);
        write_reg(REG_SAMPLE_RATE, 32'h0);
        send_item(OP_MEASURE, fill(32'sh0002_0000), fill(32'sh0000_4000));
        send_item(OP_SET_REF, fill(32'sh0003_0000), fill('0));
        send_item(OP_MEASURE, fill(32'sh0002_8000), fill(VALUE_MIN));
        settle();
        write_reg(REG_OUTER_GAIN, 32'h0000_0100);
        write_reg(REG_INNER_GAIN, 32'h0000_0001);
        write_reg(REG_SAMPLE_RATE, 32'h0000_0001);
        for (int k = 0; k < 2; k++) begin
            for (int j = 0; j < JOINTS; j++) rnd[j] = rand_value();
            send_item(OP_MEASURE, rnd, ~rnd);
        end
    endtask

    task automatic randomize_registers();
        settle();
        write_reg(REG_OUTER_GAIN, {16'($urandom()), rand_gain()});
        write_reg(REG_INNER_GAIN, {16'($urandom()), rand_gain()});
        write_reg(REG_SAMPLE_RATE, {16'($urandom()), rand_rate()});
        for (int j = 0; j < JOINTS; j++)
            write_reg(CFG_IDX_W'(REG_START_REF0 + j), rand_value());
    endtask

    task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int count);
        t_joint_vec refs, vals, spds;
        int sent;
        int bursts;
        sent = 0;
        randomize_registers();
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        while (sent < count) begin
            if ($urandom_range(99) < 3) settle();
            if ($urandom_range(99) < 85) begin
                // new reference, then a few measurements around it
                for (int j = 0; j < JOINTS; j++) begin
                    refs[j] = rand_value();
                    spds[j] = $urandom();
                end
                send_item(OP_SET_REF, refs, spds);
                sent++;
                bursts = $urandom_range(1, 6);
                repeat (bursts) begin
                    for (int j = 0; j < JOINTS; j++) begin
                        vals[j] = ($urandom_range(9) == 0) ? rand_value() : near(refs[j]);
                        spds[j] = rand_speed();
                    end
                    send_item(OP_MEASURE, vals, spds);
                    sent++;
                end
            end else begin
                for (int j = 0; j < JOINTS; j++) begin
                    vals[j] = $urandom();
                    spds[j] = $urandom();
                end
                send_item(logic'($urandom_range(1)), vals, spds);
                sent++;
            end
        end
    endtask

    initial begin
        tx_idle_pct = 30;
        rx_idle_pct = 78;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_measure_before_reference();
        test_reset_registers();
        test_field_extremes();
        test_register_writes();
        test_random_traffic(30, 78, 600);
        test_random_traffic(78, 30, 600);
        test_random_traffic(0, 0, 600);
        settle();
        if (fail_count == 0 && pending_drives.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #(LIMIT_TIME);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ discrete_backstepping_joint_control.f @@
src/dbjc_pkg.sv
src/dbjc_ctrl.sv
src/dbjc_datapath.sv
src/discrete_backstepping_joint_control.sv
tb/discrete_backstepping_joint_control_tb.sv
